/* sv/nsr_pkg.sv */
// Package with the widths, register indexes, types and constants of the Newton square root block.
package nsr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int T_W        = DATA_WIDTH + FRAC_BITS;
    localparam int S_W        = 2 * DATA_WIDTH;
    localparam int SHIFT_W    = 5;
    localparam int LIMIT_W    = 6;
    localparam int CFG_DATA_W = 6;
    localparam int DIV_STEPS  = T_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int M_USED_W   = DATA_WIDTH + LIMIT_W + 1;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_USED_W;

    localparam logic [SHIFT_W-1:0] TOL_SHIFT_RESET = SHIFT_W'(20);
    localparam logic [LIMIT_W-1:0] ITER_LIMIT_RESET = LIMIT_W'(40);

    typedef enum logic [0:0] {
        CFG_TOLERANCE_SHIFT = 1'b0,
        CFG_ITERATION_LIMIT = 1'b1
    } nsr_cfg_index_t;

    typedef struct packed {
        logic load;
        logic square;
        logic diff;
        logic div_start;
        logic update;
        logic set_conv;
        logic out_load;
    } nsr_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic close;
        logic limit_hit;
        logic div_done;
        logic no_change;
        logic out_busy;
    } nsr_status_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SQUARE = 7'b0000010,
        ST_DIFF   = 7'b0000100,
        ST_CHECK  = 7'b0001000,
        ST_DIVIDE = 7'b0010000,
        ST_UPDATE = 7'b0100000,
        ST_FINISH = 7'b1000000
    } nsr_state_t;

endpackage

/* sv/nsr_divider.sv */
// Bit-serial restoring divider that forms a saturated quotient one bit per cycle.
module nsr_divider
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [nsr_pkg::T_W-1:0]        dividend,
    input  logic [nsr_pkg::DATA_WIDTH-1:0] divisor,
    output logic [nsr_pkg::DATA_WIDTH-1:0] quotient,
    output logic                         done
);
    import nsr_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [T_W-1:0]        n_reg;
    logic [T_W-1:0]        q_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] d_reg;
    logic [DATA_WIDTH:0]   trial;
    logic                  fits;

    assign trial = {rem_reg, n_reg[T_W-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= dividend;
            d_reg   <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[T_W-2:0], 1'b0};
            q_reg <= {q_reg[T_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= DATA_WIDTH'(trial - {1'b0, d_reg});
            end
            else
            begin
                rem_reg <= trial[DATA_WIDTH-1:0];
            end
        end
    end

    assign quotient = (|q_reg[T_W-1:DATA_WIDTH]) ? {DATA_WIDTH{1'b1}} : q_reg[DATA_WIDTH-1:0];
    assign done     = done_reg;

endmodule

/* sv/nsr_datapath.sv */
// Datapath with the guess, the squaring, the tolerance test, the divider and the output register.
module nsr_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  nsr_pkg::nsr_cmd_t              cmd,
    output nsr_pkg::nsr_status_t           status,
    input  logic [nsr_pkg::DATA_WIDTH-1:0] x_value,
    input  logic [nsr_pkg::SHIFT_W-1:0]    tolerance_shift,
    input  logic [nsr_pkg::LIMIT_W-1:0]    iteration_limit,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [nsr_pkg::M_TDATA_W-1:0]  out_data
);
    import nsr_pkg::*;

    logic [DATA_WIDTH-1:0] g_reg;
    logic [T_W-1:0]        t_reg;
    logic [S_W-1:0]        s_reg;
    logic [S_W-1:0]        d_reg;
    logic [S_W-1:0]        ts_reg;
    logic [S_W-1:0]        ss_reg;
    logic [LIMIT_W-1:0]    steps_reg;
    logic                  conv_reg;
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_root_reg;
    logic [LIMIT_W-1:0]    out_steps_reg;
    logic                  out_conv_reg;
    logic [S_W-1:0]        t_wide;
    logic [DATA_WIDTH-1:0] q;
    logic                  q_done;
    logic [DATA_WIDTH:0]   sum;
    logic [DATA_WIDTH-1:0] ng;

    nsr_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (t_reg),
        .divisor  (g_reg),
        .quotient (q),
        .done     (q_done)
    );

    assign t_wide = {{(S_W - T_W){1'b0}}, t_reg};
    assign sum    = {1'b0, g_reg} + {1'b0, q};
    assign ng     = sum[DATA_WIDTH:1];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            g_reg <= x_value;
            t_reg <= {x_value, {FRAC_BITS{1'b0}}};
        end
        else if (cmd.update)
        begin
            g_reg <= ng;
        end
        if (cmd.square)
        begin
            s_reg <= S_W'(g_reg) * S_W'(g_reg);
        end
        if (cmd.diff)
        begin
            d_reg  <= (s_reg >= t_wide) ? (s_reg - t_wide) : (t_wide - s_reg);
            ts_reg <= t_wide >> tolerance_shift;
            ss_reg <= s_reg >> tolerance_shift;
        end
        if (cmd.out_load)
        begin
            out_root_reg  <= g_reg;
            out_steps_reg <= steps_reg;
            out_conv_reg  <= conv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg     <= '0;
            conv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                steps_reg <= '0;
                conv_reg  <= (x_value == '0);
            end
            else
            begin
                if (cmd.update)
                begin
                    steps_reg <= steps_reg + 1'b1;
                end
                if (cmd.set_conv)
                begin
                    conv_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.in_zero   = (x_value == '0);
    assign status.close     = (d_reg <= ts_reg) && (d_reg <= ss_reg);
    assign status.limit_hit = (steps_reg >= iteration_limit);
    assign status.div_done  = q_done;
    assign status.no_change = (ng == g_reg);
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = {{M_PAD_W{1'b0}}, out_conv_reg, out_steps_reg, out_root_reg};

endmodule

/* sv/nsr_controller.sv */
// Controller state machine that sequences the Newton steps of one operand.
module nsr_controller
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  nsr_pkg::nsr_status_t status,
    output nsr_pkg::nsr_cmd_t    cmd
);
    import nsr_pkg::*;

    nsr_state_t state_reg;
    nsr_state_t state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.in_zero ? ST_FINISH : ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (status.close)
                begin
                    cmd.set_conv = 1'b1;
                    state_next   = ST_FINISH;
                end
                else if (status.limit_hit)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (status.no_change)
                begin
                    cmd.set_conv = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/newton_square_root_top.sv */
// Top level of the Newton square root block with its configuration registers.
// The block takes one unsigned Q16.16 word and returns its square root in Q16.16,
// the number of Newton steps made and a converged flag; it works on one word at a
// time and takes the next word while a finished result still waits at the output.
// A zero operand goes from the idle state straight to the finish state. Any other
// operand runs Newton steps, each a squaring, a tolerance test, a pass through the
// bit-serial divider, one quotient bit per cycle, and an update; the iteration
// limit bounds the number of steps.
module newton_square_root_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [nsr_pkg::DATA_WIDTH-1:0] s_tdata,  // x_value
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [nsr_pkg::M_TDATA_W-1:0]  m_tdata,  // root, steps_taken, converged, zero fill
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  nsr_pkg::nsr_cfg_index_t        cfg_index,
    input  logic [nsr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nsr_pkg::*;

    logic [SHIFT_W-1:0] tol_shift_reg;
    logic [LIMIT_W-1:0] iter_limit_reg;
    nsr_cmd_t           cmd;
    nsr_status_t        status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_shift_reg  <= TOL_SHIFT_RESET;
            iter_limit_reg <= ITER_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TOLERANCE_SHIFT: tol_shift_reg  <= cfg_data[SHIFT_W-1:0];
                CFG_ITERATION_LIMIT: iter_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:             tol_shift_reg  <= tol_shift_reg;
            endcase
        end
    end

    nsr_controller u_controller
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nsr_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .x_value         (s_tdata),
        .tolerance_shift (tol_shift_reg),
        .iteration_limit (iter_limit_reg),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_data        (m_tdata)
    );

endmodule

/* sv/nsr_checker.sv */
// Checker on the ports of the Newton square root block, bound to its top level.
module nsr_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [nsr_pkg::DATA_WIDTH-1:0] s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [nsr_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                         cfg_valid,
    input logic                         cfg_ready
);
    import nsr_pkg::*;

    // A result word that is not taken holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Only a zero operand can give a zero root, and it converges with no steps.
    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[DATA_WIDTH-1:0] == '0) |->
            m_tdata[DATA_WIDTH+LIMIT_W] && (m_tdata[DATA_WIDTH+LIMIT_W-1:DATA_WIDTH] == '0))
        else $error("zero root without zero-operand result fields");

    // The block works on one operand at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while an operand is at work");

    // A zero operand taken while the output is empty passes through the finish state to a valid zero result.
    a_zero_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata == '0) && !m_tvalid |=>
            ##1 m_tvalid && (m_tdata[DATA_WIDTH-1:0] == '0))
        else $error("zero operand did not finish in two cycles");

    // Configuration writes are never stalled.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind newton_square_root_top nsr_checker u_nsr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
